@@ sv/sfrc_pkg.sv @@
// shared types and constants of the square-free range counter
`timescale 1ns / 1ps
`default_nettype none
package sfrc_pkg;

   localparam int CountWidth = 21;

   typedef enum logic [13:0] {
      S_IDLE     = 14'b00000000000001,
      S_ROOT     = 14'b00000000000010,
      S_INIT     = 14'b00000000000100,
      S_SV_RD    = 14'b00000000001000,
      S_SV_CHK   = 14'b00000000010000,
      S_SV_Q     = 14'b00000000100000,
      S_CLEAR    = 14'b00000001000000,
      S_MK_RD    = 14'b00000010000000,
      S_MK_CHK   = 14'b00000100000000,
      S_MK_DIV   = 14'b00001000000000,
      S_MK_SET   = 14'b00010000000000,
      S_CNT      = 14'b00100000000000,
      S_CNT_TAIL = 14'b01000000000000,
      S_DONE     = 14'b10000000000000
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage
`default_nettype wire

@@ sv/sfrc_isqrt.sv @@
// iterative integer square root, two input bits per cycle
`timescale 1ns / 1ps
`default_nettype none
module sfrc_isqrt #(
   parameter int W = 40
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  wire logic [W-1:0]          value,
   output sfrc_pkg::unit_status_type  status,
   output logic [(W+1)/2-1:0]         root
);
   localparam int N  = (W + 1) / 2;
   localparam int CB = $clog2(N + 1);

   logic [2*N-1:0] x_ff, x_in;
   logic [N+1:0]   rem_ff, rem_in;
   logic [N-1:0]   root_ff, root_in;
   logic [CB-1:0]  cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [N+3:0]   rem_sh;
   logic [N+3:0]   trial;

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, x_ff[2*N-1 -: 2]};
      trial   = (N+4)'({root_ff, 2'b01});
      if (go && !busy_ff) begin
         x_in    = (2*N)'(value);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         x_in = {x_ff[2*N-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = (N+2)'(rem_sh - trial);
            root_in = {root_ff[N-2:0], 1'b1};
         end else begin
            rem_in  = (N+2)'(rem_sh);
            root_in = {root_ff[N-2:0], 1'b0};
         end
         if (cnt_ff == CB'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = root_ff;

endmodule
`default_nettype wire

@@ sv/sfrc_divider.sv @@
// iterative restoring divider, remainder only, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module sfrc_divider #(
   parameter int W = 40
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  go,
   input  wire logic [W-1:0]          dividend,
   input  wire logic [W-1:0]          divisor,
   output sfrc_pkg::unit_status_type  status,
   output logic [W-1:0]               remainder
);
   localparam int CB = $clog2(W + 1);

   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [CB-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    rem_sh;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, num_ff[W-1]};
      if (go && !busy_ff) begin
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[W-2:0], 1'b0};
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = W'(rem_sh - {1'b0, den_ff});
         end else begin
            rem_in = W'(rem_sh);
         end
         if (cnt_ff == CB'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (den_ff == '0 || rem_ff < den_ff))
      else $error("remainder not below divisor");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

   a_go_starts: assert property (@(posedge clock) disable iff (reset)
      (go && !busy_ff) |=> busy_ff)
      else $error("divider did not start");

endmodule
`default_nettype wire

@@ sv/square_free_range_counter.sv @@
// top level: segmented sieve square-free counter over a range
//
//   channel   ports                                        handshake
//   request   req_range_low, req_range_high                start / busy
//   response  rsp_square_free_count, rsp_range_error       rsp_valid strobe
//
// an item runs the root step, the sieve fill up to bound, the sieve pass that crosses
// off the multiples of each prime from its square, the window clear over the span,
// then per marking candidate a read and a check, and per prime a divide of low by p^2
// and a marking walk, and last the count walk over the span; the run time is set by
// the bitmap walks and one divide per prime
// a rejected range answers in the cycle right after acceptance
// reset is synchronous; every range that is not rejected rewrites the sieve bitmap up to its bound
// the receiver cannot stall: the result is shown for one cycle
`timescale 1ns / 1ps
`default_nettype none
module square_free_range_counter #(
   parameter int WINDOW_SIZE = 1048576,
   parameter int SIEVE_LIMIT = 1048576,
   parameter int VALUE_BITS  = 40
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [VALUE_BITS-1:0]           req_range_low,
   input  wire logic [VALUE_BITS-1:0]           req_range_high,
   output logic                                 rsp_valid,
   output logic [sfrc_pkg::CountWidth-1:0]      rsp_square_free_count,
   output logic                                 rsp_range_error
);
   localparam int V   = VALUE_BITS;
   localparam int V1  = V + 1;
   localparam int N   = (V + 1) / 2;
   localparam int N2  = N + 2;
   localparam int SA  = $clog2(SIEVE_LIMIT);
   localparam int SA1 = SA + 1;
   localparam int SA2 = SA + 2;
   localparam int WA  = $clog2(WINDOW_SIZE);
   localparam int SQW = 2 * SA1;
   localparam int CW0 = (SQW > V) ? SQW : V;
   localparam int CW  = (CW0 > WA) ? CW0 + 1 : WA + 1;
   localparam int CNW = sfrc_pkg::CountWidth;

   sfrc_pkg::state_type state_ff, state_in;

   logic [V-1:0]   low_ff, low_in;
   logic [V-1:0]   high_ff, high_in;
   logic [WA-1:0]  span_ff, span_in;
   logic [SA-1:0]  bound_ff, bound_in;
   logic [SA1-1:0] p_ff, p_in;
   logic [SA1-1:0] q_ff, q_in;
   logic [SQW-1:0] sq_ff, sq_in;
   logic [V1-1:0]  off_ff, off_in;
   logic [WA-1:0]  idx_ff, idx_in;
   logic [CNW-1:0] cnt_ff, cnt_in;
   logic           err_ff, err_in;
   logic           rdv_ff;

   logic           accept;
   logic [V1-1:0]  diff;
   logic           bad;
   logic [N2-1:0]  bnd_raw;
   logic [SA2-1:0] q_next;

   logic           root_go, div_go;
   logic [N-1:0]   root;
   logic [V-1:0]   rem;
   sfrc_pkg::unit_status_type root_st, div_st;

   logic           sv_we, sv_wd, sv_q;
   logic [SA-1:0]  sv_wa, sv_ra;
   logic           wn_we, wn_wd, wn_q;
   logic [WA-1:0]  wn_wa;

   logic sieve_mem [SIEVE_LIMIT];
   logic win_mem   [WINDOW_SIZE];

   assign accept  = start && !busy;
   assign diff    = {1'b0, req_range_high} - {1'b0, req_range_low};
   assign bad     = diff[V] || (64'(diff[V-1:0]) >= 64'(WINDOW_SIZE));
   assign bnd_raw = root[0] ? N2'(root) + N2'(2) : N2'(root) + N2'(1);
   assign q_next  = SA2'(q_ff) + SA2'(p_ff);
   assign root_go = accept && !bad;

   sfrc_isqrt #(.W(V)) u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .go     (root_go),
      .value  (req_range_high),
      .status (root_st),
      .root   (root)
   );

   sfrc_divider #(.W(V)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .go        (div_go),
      .dividend  (low_ff),
      .divisor   (V'(sq_ff)),
      .status    (div_st),
      .remainder (rem)
   );

   always_comb begin
      state_in = state_ff;
      low_in   = low_ff;
      high_in  = high_ff;
      span_in  = span_ff;
      bound_in = bound_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      sq_in    = sq_ff;
      off_in   = off_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      err_in   = err_ff;
      div_go   = 1'b0;
      sv_we    = 1'b0;
      sv_wd    = 1'b0;
      sv_wa    = SA'(p_ff);
      sv_ra    = SA'(p_ff);
      wn_we    = 1'b0;
      wn_wd    = 1'b0;
      wn_wa    = idx_ff;
      unique case (state_ff)
         sfrc_pkg::S_IDLE: begin
            if (accept) begin
               low_in  = req_range_low;
               high_in = req_range_high;
               span_in = WA'(diff);
               cnt_in  = '0;
               err_in  = bad;
               state_in = bad ? sfrc_pkg::S_DONE : sfrc_pkg::S_ROOT;
            end
         end
         sfrc_pkg::S_ROOT: begin
            if (root_st.done) begin
               if (64'(bnd_raw) > 64'(SIEVE_LIMIT - 1)) begin
                  bound_in = SA'(SIEVE_LIMIT - 1);
               end else begin
                  bound_in = SA'(bnd_raw);
               end
               p_in     = '0;
               state_in = sfrc_pkg::S_INIT;
            end
         end
         sfrc_pkg::S_INIT: begin
            sv_we = 1'b1;
            sv_wd = (p_ff >= SA1'(2));
            if (p_ff == SA1'(bound_ff)) begin
               p_in     = SA1'(2);
               state_in = sfrc_pkg::S_SV_RD;
            end else begin
               p_in = p_ff + 1'b1;
            end
         end
         sfrc_pkg::S_SV_RD: begin
            sq_in    = SQW'(p_ff) * SQW'(p_ff);
            state_in = sfrc_pkg::S_SV_CHK;
         end
         sfrc_pkg::S_SV_CHK: begin
            if (sq_ff > SQW'(bound_ff)) begin
               idx_in   = '0;
               state_in = sfrc_pkg::S_CLEAR;
            end else if (sv_q) begin
               q_in     = SA1'(sq_ff);
               state_in = sfrc_pkg::S_SV_Q;
            end else begin
               p_in     = p_ff + 1'b1;
               state_in = sfrc_pkg::S_SV_RD;
            end
         end
         sfrc_pkg::S_SV_Q: begin
            sv_we = 1'b1;
            sv_wd = 1'b0;
            sv_wa = SA'(q_ff);
            if (q_next > SA2'(bound_ff)) begin
               p_in     = p_ff + 1'b1;
               state_in = sfrc_pkg::S_SV_RD;
            end else begin
               q_in = SA1'(q_next);
            end
         end
         sfrc_pkg::S_CLEAR: begin
            wn_we = 1'b1;
            wn_wd = 1'b0;
            if (idx_ff == span_ff) begin
               p_in     = SA1'(2);
               state_in = sfrc_pkg::S_MK_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         sfrc_pkg::S_MK_RD: begin
            sq_in    = SQW'(p_ff) * SQW'(p_ff);
            state_in = sfrc_pkg::S_MK_CHK;
         end
         sfrc_pkg::S_MK_CHK: begin
            if (p_ff > SA1'(bound_ff)) begin
               idx_in   = '0;
               state_in = sfrc_pkg::S_CNT;
            end else if (!sv_q) begin
               p_in     = p_ff + 1'b1;
               state_in = sfrc_pkg::S_MK_RD;
            end else if (CW'(sq_ff) > CW'(high_ff)) begin
               idx_in   = '0;
               state_in = sfrc_pkg::S_CNT;
            end else begin
               div_go   = 1'b1;
               state_in = sfrc_pkg::S_MK_DIV;
            end
         end
         sfrc_pkg::S_MK_DIV: begin
            if (div_st.done) begin
               if (rem == '0) begin
                  off_in = '0;
               end else begin
                  off_in = V1'(sq_ff) - V1'(rem);
               end
               state_in = sfrc_pkg::S_MK_SET;
            end
         end
         sfrc_pkg::S_MK_SET: begin
            if (CW'(off_ff) > CW'(span_ff)) begin
               p_in     = p_ff + 1'b1;
               state_in = sfrc_pkg::S_MK_RD;
            end else begin
               wn_we  = 1'b1;
               wn_wd  = 1'b1;
               wn_wa  = WA'(off_ff);
               off_in = off_ff + V1'(sq_ff);
            end
         end
         sfrc_pkg::S_CNT: begin
            if (rdv_ff && !wn_q) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (idx_ff == span_ff) begin
               state_in = sfrc_pkg::S_CNT_TAIL;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         sfrc_pkg::S_CNT_TAIL: begin
            if (rdv_ff && !wn_q) begin
               cnt_in = cnt_ff + 1'b1;
            end
            state_in = sfrc_pkg::S_DONE;
         end
         sfrc_pkg::S_DONE: begin
            state_in = sfrc_pkg::S_IDLE;
         end
         default: begin
            state_in = sfrc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      low_ff   <= low_in;
      high_ff  <= high_in;
      span_ff  <= span_in;
      bound_ff <= bound_in;
      p_ff     <= p_in;
      q_ff     <= q_in;
      sq_ff    <= sq_in;
      off_ff   <= off_in;
      idx_ff   <= idx_in;
      cnt_ff   <= cnt_in;
      err_ff   <= err_in;
      if (reset) begin
         state_ff <= sfrc_pkg::S_IDLE;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= (state_ff == sfrc_pkg::S_CNT);
      end
   end

   always_ff @(posedge clock) begin
      if (sv_we) begin
         sieve_mem[sv_wa] <= sv_wd;
      end
      sv_q <= sieve_mem[sv_ra];
   end

   always_ff @(posedge clock) begin
      if (wn_we) begin
         win_mem[wn_wa] <= wn_wd;
      end
      wn_q <= win_mem[idx_ff];
   end

   assign busy                  = (state_ff != sfrc_pkg::S_IDLE);
   assign rsp_valid             = (state_ff == sfrc_pkg::S_DONE);
   assign rsp_square_free_count = cnt_ff;
   assign rsp_range_error       = err_ff;

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("item accepted but block not busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_square_free_count == '0))
      else $error("error result with nonzero count");

   a_div_idle_on_go: assert property (@(posedge clock) disable iff (reset)
      div_go |-> !div_st.busy)
      else $error("divider started while busy");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// testbench for the square-free range counter: directed and random ranges
`timescale 1ns / 1ps
module tb;

   localparam int ValueBits = 40;
   localparam int Window = 1048576;
   localparam longint unsigned ValueMax = (64'd1 << ValueBits) - 1;

   logic clock;
   logic reset;
   logic start;
   logic busy;
   logic [ValueBits-1:0] req_range_low;
   logic [ValueBits-1:0] req_range_high;
   logic rsp_valid;
   logic [sfrc_pkg::CountWidth-1:0] rsp_square_free_count;
   logic rsp_range_error;

   square_free_range_counter dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_range_low(req_range_low),
      .req_range_high(req_range_high),
      .rsp_valid(rsp_valid),
      .rsp_square_free_count(rsp_square_free_count),
      .rsp_range_error(rsp_range_error)
   );

   typedef struct {
      logic [sfrc_pkg::CountWidth-1:0] count;
      logic err;
   } sf_result_type;

   sf_result_type pending_counts[$];
   int prime_list[$];
   int mismatches = 0;
   int items_sent = 0;
   int errors_sent = 0;
   int results_seen = 0;
   bit allow_gaps = 1;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400_000_000;
      $display("square_free_range_counter verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   task automatic build_prime_list();
      bit composite[];
      composite = new[1024 * 1024];
      for (int p = 2; p < 1024 * 1024; p++) begin
         if (!composite[p]) begin
            prime_list.insert(prime_list.size(), p);
            for (longint q = longint'(p) * p; q < 1024 * 1024; q += p) composite[q] = 1;
         end
      end
   endtask

   function automatic sf_result_type count_square_free(input longint unsigned lo,
                                                       input longint unsigned hi);
      sf_result_type r;
      bit marks[];
      longint unsigned span, sq, m;
      int total;
      r.count = '0;
      r.err = 1'b1;
      if (lo > hi || (hi - lo) >= Window) return r;
      span = hi - lo + 1;
      marks = new[span];
      foreach (prime_list[i]) begin
         sq = longint'(prime_list[i]) * prime_list[i];
         if (sq > hi) break;
         m = ((lo + sq - 1) / sq) * sq;
         for (; m <= hi; m += sq) marks[m - lo] = 1;
      end
      total = 0;
      foreach (marks[i]) if (!marks[i]) total++;
      r.count = total[sfrc_pkg::CountWidth-1:0];
      r.err = 1'b0;
      return r;
   endfunction

   task automatic send_range(input longint unsigned lo, input longint unsigned hi);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      start <= 1'b1;
      req_range_low <= lo[ValueBits-1:0];
      req_range_high <= hi[ValueBits-1:0];
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_counts.insert(pending_counts.size(), count_square_free(lo, hi));
      items_sent++;
      if (lo > hi || (hi - lo) >= Window) errors_sent++;
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_counts.size() == 0) begin
            report_mismatch("unexpected result", rsp_square_free_count, 0);
         end else begin
            sf_result_type exp_r;
            exp_r = pending_counts.pop_front();
            if (rsp_square_free_count !== exp_r.count)
               report_mismatch("count", rsp_square_free_count, exp_r.count);
            if (rsp_range_error !== exp_r.err)
               report_mismatch("error flag", rsp_range_error, exp_r.err);
            results_seen++;
         end
      end
   end

   task automatic test_small_ranges();
      send_range(1, 1);
      send_range(4, 4);
      send_range(0, 0);
      send_range(0, 10);
      send_range(1, 100);
      send_range(8, 12);
      send_range(1000, 1100);
      send_range(999_900, 1_000_100);
   endtask

   task automatic test_range_errors();
      send_range(5, 3);
      send_range(1, Window + 1);
      send_range(0, ValueMax);
      send_range(ValueMax, ValueMax - 1);
      send_range(ValueMax, 1);
      send_range(64'h55_5555_5555, 64'h2A_AAAA_AAAA);
   endtask

   task automatic test_extreme_ranges();
      send_range(1, Window);
      send_range((64'd1 << 36) - 50, 64'd1 << 36);
      send_range((64'd1 << 32) - 1000, (64'd1 << 32) + 24);
   endtask

   task automatic test_random_ranges(input int n);
      longint unsigned lo, hi;
      int kind;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            hi = $urandom_range(1, 1 << 20);
            lo = hi - $urandom_range(0, (hi < 300) ? hi : 300);
         end else if (kind == 6) begin
            hi = $urandom_range(1 << 20, 1 << 24);
            lo = hi - $urandom_range(0, 200);
         end else if (kind == 7) begin
            hi = {$urandom, $urandom} & ValueMax;
            lo = hi + $urandom_range(1, 1000);
            if (lo > ValueMax) lo = ValueMax;
            if (hi == ValueMax) hi = hi - 1;
         end else if (kind == 8) begin
            lo = $urandom_range(0, 1000);
            hi = lo + Window + ({$urandom, $urandom} & (ValueMax >> 1));
            if (hi > ValueMax) hi = ValueMax;
         end else begin
            lo = {$urandom, $urandom} & ValueMax;
            hi = {$urandom, $urandom} & ValueMax;
            if (hi >= lo && hi - lo < Window) hi = lo + Window;
            if (hi > ValueMax) begin
               hi = lo - 1;
            end
         end
         send_range(lo, hi);
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_range_low = '0;
      req_range_high = '0;
      build_prime_list();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_small_ranges();
      test_range_errors();
      drain();
      test_extreme_ranges();
      test_random_ranges(80);
      drain();
      allow_gaps = 0;
      test_random_ranges(20);
      drain();
      repeat (20) @(posedge clock);
      $display("covered %0d ranges, %0d of them rejected, %0d results compared",
               items_sent, errors_sent, results_seen);
      $display("ranges spanned zero, single values, the full window and values up to 2^36");
      if (mismatches == 0 && pending_counts.size() == 0) begin
         $display("square_free_range_counter verification clean");
      end else begin
         $display("square_free_range_counter verification failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
sv/sfrc_pkg.sv
sv/sfrc_isqrt.sv
sv/sfrc_divider.sv
sv/square_free_range_counter.sv
bench/tb.sv
